@@ rtl/flpte_pkg.sv @@
// ----------------------------------------------------------------------------
// flpte_pkg
// item types, operation and status codes, and page table entry fields for
// the four-level page table engine
// ----------------------------------------------------------------------------
package flpte_pkg;

  localparam int unsigned IDX_W = 9;
  localparam int unsigned ENTRY_W = 64;

  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_UNMAP  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_NO_FRAME = 3'd2;
  localparam logic [2:0] ST_HUGE     = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;

  localparam int unsigned BIT_PRESENT  = 0;
  localparam int unsigned BIT_WRITABLE = 1;
  localparam int unsigned BIT_USER     = 2;
  localparam int unsigned BIT_HUGE     = 7;
  localparam int unsigned BIT_NX       = 63;

  localparam logic [63:0] ADDR_MASK      = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] LEAF_FLAG_MASK = 64'h8000_0000_0000_0007;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] virt_addr;
    logic [63:0] target_pa;
    logic [63:0] flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] phys_result;
  } out_item_t;

  function automatic logic [IDX_W-1:0] level_index(input logic [63:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ rtl/flpte_mem.sv @@
// ----------------------------------------------------------------------------
// flpte_mem
// table frame pool: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module flpte_mem #(
  parameter int unsigned NUM_FRAMES = 64,
  localparam int unsigned AW = $clog2(NUM_FRAMES) + flpte_pkg::IDX_W,
  localparam int unsigned DEPTH = NUM_FRAMES * (2 ** flpte_pkg::IDX_W)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [flpte_pkg::ENTRY_W-1:0]  wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [flpte_pkg::ENTRY_W-1:0]  rd_data
);

  logic [flpte_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [flpte_pkg::ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/flpte_seq.sv @@
// ----------------------------------------------------------------------------
// flpte_seq
// walk sequencer: reads one table entry per level, allocates and clears
// missing tables, writes leaves and forms the result item
// ----------------------------------------------------------------------------
module flpte_seq #(
  parameter int unsigned NUM_FRAMES = 64,
  localparam int unsigned FW = $clog2(NUM_FRAMES),
  localparam int unsigned AW = FW + flpte_pkg::IDX_W,
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  flpte_pkg::in_item_t            in_item,
  input  logic                           paging_en,
  output logic                           out_valid,
  output flpte_pkg::out_item_t           out_item,
  output logic                           mem_wr_en,
  output logic [AW-1:0]                  mem_wr_addr,
  output logic [flpte_pkg::ENTRY_W-1:0]  mem_wr_data,
  output logic                           mem_rd_en,
  output logic [AW-1:0]                  mem_rd_addr,
  input  logic [flpte_pkg::ENTRY_W-1:0]  mem_rd_data
);

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_CLEAR,
    S_FIN
  } state_t;

  localparam logic [flpte_pkg::IDX_W-1:0] CLR_LAST = '1;

  state_t                        state_r;
  logic [1:0]                    op_r;
  logic [63:0]                   va_r;
  logic [63:0]                   pa_r;
  logic [63:0]                   flags_r;
  logic [FW-1:0]                 frame_r;
  logic [1:0]                    lvl_r;
  logic [CW-1:0]                 nff_r;
  logic [flpte_pkg::IDX_W-1:0]   clr_cnt_r;
  logic [FW-1:0]                 clr_frame_r;
  logic [2:0]                    status_r;
  logic [51:0]                   res_r;
  logic                          out_valid_r;
  flpte_pkg::out_item_t          out_item_r;

  logic [flpte_pkg::IDX_W-1:0]   idx;
  logic [AW-1:0]                 slot_addr;
  logic                          e_present;
  logic                          e_huge;
  logic [39:0]                   e_frame;
  logic                          e_outside;
  logic                          pool_empty;
  logic [FW-1:0]                 new_frame;
  logic [63:0]                   new_entry;
  logic [63:0]                   leaf_entry;
  logic                          is_leaf;

  always_comb begin
    idx        = flpte_pkg::level_index(va_r, lvl_r);
    slot_addr  = {frame_r, idx};
    e_present  = mem_rd_data[flpte_pkg::BIT_PRESENT];
    e_huge     = mem_rd_data[flpte_pkg::BIT_HUGE];
    e_frame    = mem_rd_data[51:12];
    e_outside  = e_frame >= 40'(NUM_FRAMES);
    pool_empty = nff_r >= CW'(NUM_FRAMES);
    new_frame  = nff_r[FW-1:0];
    is_leaf    = lvl_r == flpte_pkg::LVL_PT;

    new_entry = '0;
    new_entry[12 +: FW] = new_frame;
    new_entry[flpte_pkg::BIT_PRESENT]  = 1'b1;
    new_entry[flpte_pkg::BIT_WRITABLE] = 1'b1;
    new_entry[flpte_pkg::BIT_USER]     = flags_r[flpte_pkg::BIT_USER];

    leaf_entry = (pa_r & flpte_pkg::ADDR_MASK) | (flags_r & flpte_pkg::LEAF_FLAG_MASK);
    leaf_entry[flpte_pkg::BIT_PRESENT] = 1'b1;

    mem_rd_en   = state_r == S_RD;
    mem_rd_addr = slot_addr;

    mem_wr_en   = 1'b0;
    mem_wr_addr = slot_addr;
    mem_wr_data = '0;
    unique case (state_r)
      S_BOOT, S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = {clr_frame_r, clr_cnt_r};
      end
      S_EVAL: begin
        if (!is_leaf) begin
          mem_wr_en   = !e_present && op_r == flpte_pkg::OP_MAP && !pool_empty;
          mem_wr_data = new_entry;
        end else if (op_r == flpte_pkg::OP_MAP) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = leaf_entry;
        end else begin
          mem_wr_en   = e_present && op_r == flpte_pkg::OP_UNMAP;
        end
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      nff_r       <= CW'(1);
      clr_cnt_r   <= '0;
      clr_frame_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_BOOT: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_item.operation;
            va_r    <= in_item.virt_addr;
            pa_r    <= in_item.target_pa;
            flags_r <= in_item.flags;
            lvl_r   <= flpte_pkg::LVL_PML4;
            frame_r <= '0;
            res_r   <= '0;
            status_r <= flpte_pkg::ST_OK;
            if (in_item.operation == flpte_pkg::OP_NONE) begin
              state_r <= S_FIN;
            end else if (!paging_en) begin
              status_r <= flpte_pkg::ST_DISABLED;
              state_r  <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (!is_leaf) begin
            if (!e_present) begin
              if (op_r != flpte_pkg::OP_MAP) begin
                status_r <= flpte_pkg::ST_ABSENT;
                state_r  <= S_FIN;
              end else if (pool_empty) begin
                status_r <= flpte_pkg::ST_NO_FRAME;
                state_r  <= S_FIN;
              end else begin
                nff_r       <= nff_r + 1'b1;
                clr_frame_r <= new_frame;
                frame_r     <= new_frame;
                clr_cnt_r   <= '0;
                state_r     <= S_CLEAR;
              end
            end else if (e_huge) begin
              status_r <= flpte_pkg::ST_HUGE;
              state_r  <= S_FIN;
            end else if (e_outside) begin
              status_r <= flpte_pkg::ST_ABSENT;
              state_r  <= S_FIN;
            end else begin
              frame_r <= e_frame[FW-1:0];
              lvl_r   <= lvl_r + 1'b1;
              state_r <= S_RD;
            end
          end else begin
            if (op_r != flpte_pkg::OP_MAP && !e_present) begin
              status_r <= flpte_pkg::ST_ABSENT;
            end else if (op_r == flpte_pkg::OP_LOOKUP) begin
              res_r <= mem_rd_data[51:0] & flpte_pkg::ADDR_MASK[51:0];
            end
            state_r <= S_FIN;
          end
        end
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLR_LAST) begin
            lvl_r   <= lvl_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_item_r  <= '{status: status_r, phys_result: res_r};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/four_level_page_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_engine_unit
// x86-64 style four-level page table engine over an internal frame pool
// ----------------------------------------------------------------------------
// After reset the block stays busy while it clears the root frame, one entry
// per cycle through the single write port of the pool. An item is taken when
// start is high and busy is low; its result appears on out_item for exactly
// one cycle with out_valid high, and must be taken then. An unused operation
// code or a disabled engine goes from idle straight to the finish state, with
// no walk. A walk reads each level through the one pool read port (address,
// then registered data); every table that a map creates adds a clear of its
// frame before the walk goes on. busy stays high until the cycle in which
// the result is shown, and the next item may start in that cycle. The
// paging_enabled register is written over the cfg channel, which is always
// ready.
module four_level_page_table_engine_unit #(
  parameter int unsigned NUM_FRAMES = 64,
  localparam int unsigned AW = $clog2(NUM_FRAMES) + flpte_pkg::IDX_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  flpte_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output flpte_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  logic                          paging_en_r;
  logic                          mem_wr_en;
  logic [AW-1:0]                 mem_wr_addr;
  logic [flpte_pkg::ENTRY_W-1:0] mem_wr_data;
  logic                          mem_rd_en;
  logic [AW-1:0]                 mem_rd_addr;
  logic [flpte_pkg::ENTRY_W-1:0] mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      paging_en_r <= cfg_data;
    end
  end

  flpte_mem #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  flpte_seq #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .paging_en   (paging_en_r),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in flight");

  a_fail_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != flpte_pkg::ST_OK |-> out_item.phys_result == '0)
    else $error("failed item carries an address");

endmodule
